FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is high.
`define SVCN_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked property that is also checked across reset.
`define SVCN_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/svcn_pkg.sv
// ----------------------------------------------------------------------------
// svcn_pkg
// Codes, fixed widths and controller/datapath interface types of the
// snapshot vector clock node.
// ----------------------------------------------------------------------------
package svcn_pkg;

   localparam int NODES = 3;

   localparam logic [1:0] NODE_MAX = 2'd2;

   // opcodes
   localparam logic [2:0] OP_INTERNAL = 3'd0;
   localparam logic [2:0] OP_SEND     = 3'd1;
   localparam logic [2:0] OP_RECV     = 3'd2;
   localparam logic [2:0] OP_MARKER   = 3'd3;
   localparam logic [2:0] OP_START    = 3'd4;

   // result kinds
   localparam logic [2:0] KIND_CLOCK  = 3'd0;
   localparam logic [2:0] KIND_MSG    = 3'd1;
   localparam logic [2:0] KIND_MARKER = 3'd2;
   localparam logic [2:0] KIND_LOCAL  = 3'd3;
   localparam logic [2:0] KIND_HEADER = 3'd4;
   localparam logic [2:0] KIND_LABEL  = 3'd5;

   localparam logic [7:0] MARK_LABEL = 8'd77;

   typedef struct packed {
      logic       load;         // latch the accepted item
      logic       apply_event;  // merge / bump the clock, record a label
      logic       begin_snap;   // capture clock, mark first channel
      logic       set_mark;     // marker on an active snapshot
      logic       finish;       // clear snapshot state after the report
      logic       ch_next;      // move to the second other node
      logic       rd_en;        // read a recorded label
      logic       rd_next;      // 0: first label of channel, 1: following one
      logic       emit;         // load the result register
      logic [2:0] kind;
      logic       last;
   } svcn_cmd_type;

   typedef struct packed {
      logic [2:0] opcode;
      logic       item_ok;      // item produces any effect at all
      logic       active;
      logic       done;         // marker would complete the snapshot
      logic       second;       // working on the second other node
      logic       cnt_zero;     // current channel has no labels
      logic       lbl_end;      // label in read data is the channel's last
      logic       slot_free;    // result register can take a result
   } svcn_sts_type;

endpackage

FILE: rtl/core/svcn_ram.sv
// ----------------------------------------------------------------------------
// svcn_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svcn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 48
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/svcn_ctl.sv
// ----------------------------------------------------------------------------
// svcn_ctl
// Controller: takes one item, runs its event, markers or snapshot report
// and issues commands to the datapath.
// ----------------------------------------------------------------------------
module svcn_ctl import svcn_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  svcn_sts_type sts,
   output svcn_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_MARK2 = 3'd2;
   localparam logic [2:0] S_HDR   = 3'd3;
   localparam logic [2:0] S_LBL   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (!sts.item_ok) begin
               state_in = S_IDLE;
            end else if (sts.opcode == OP_MARKER && sts.active) begin
               if (!sts.done) begin
                  cmd.set_mark = 1'b1;
                  state_in     = S_IDLE;
               end else if (sts.slot_free) begin
                  cmd.set_mark = 1'b1;
                  cmd.emit     = 1'b1;
                  cmd.kind     = KIND_LOCAL;
                  state_in     = S_HDR;
               end
            end else if (sts.opcode == OP_MARKER || sts.opcode == OP_START) begin
               if (sts.slot_free) begin
                  cmd.begin_snap = 1'b1;
                  cmd.emit       = 1'b1;
                  cmd.kind       = KIND_MARKER;
                  cmd.ch_next    = 1'b1;
                  state_in       = S_MARK2;
               end
            end else if (sts.slot_free) begin
               cmd.apply_event = 1'b1;
               cmd.emit        = 1'b1;
               cmd.kind        = (sts.opcode == OP_SEND) ? KIND_MSG : KIND_CLOCK;
               cmd.last        = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_MARK2: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_MARKER;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_HDR: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_HEADER;
               cmd.last = sts.second && sts.cnt_zero;
               if (!sts.cnt_zero) begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_LBL;
               end else if (!sts.second) begin
                  cmd.ch_next = 1'b1;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         S_LBL: begin
            if (sts.slot_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_LABEL;
               cmd.last = sts.second && sts.lbl_end;
               if (!sts.lbl_end) begin
                  // fetch the next label while this one goes out
                  cmd.rd_en   = 1'b1;
                  cmd.rd_next = 1'b1;
               end else if (!sts.second) begin
                  cmd.ch_next = 1'b1;
                  state_in    = S_HDR;
               end else begin
                  cmd.finish = 1'b1;
                  state_in   = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/svcn_dp.sv
// ----------------------------------------------------------------------------
// svcn_dp
// Datapath: vector clock, snapshot state, channel label store and the
// result register.
// ----------------------------------------------------------------------------
module svcn_dp import svcn_pkg::*; #(
   parameter int CHANNEL_DEPTH = 16,
   parameter int CLOCK_BITS    = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic [1:0]   csr_wr_data,
   input  logic [2:0]   req_opcode,
   input  logic [1:0]   req_peer,
   input  logic [7:0]   req_label,
   input  logic [15:0]  req_clock [NODES],
   input  svcn_cmd_type cmd,
   output svcn_sts_type sts,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [2:0]   rsp_kind,
   output logic [1:0]   rsp_target,
   output logic [7:0]   rsp_label,
   output logic [4:0]   rsp_count,
   output logic [15:0]  rsp_clock [NODES],
   output logic         rsp_last
);

   localparam int CW = $clog2(CHANNEL_DEPTH + 1);
   localparam int SD = NODES * CHANNEL_DEPTH;
   localparam int AW = $clog2(SD);
   localparam int XW = (CLOCK_BITS > 16) ? CLOCK_BITS : 16;
   localparam logic [CLOCK_BITS-1:0] CLOCK_MAX = '1;

   // architectural state
   logic [1:0]            node_ff, node_in;
   logic [CLOCK_BITS-1:0] clk_ff [NODES];
   logic [CLOCK_BITS-1:0] clk_in [NODES];
   logic [CLOCK_BITS-1:0] rec_ff [NODES];
   logic [CLOCK_BITS-1:0] rec_in [NODES];
   logic                  active_ff, active_in;
   logic [NODES-1:0]      seen_ff, seen_in;
   logic [CW-1:0]         cnt_ff [NODES];
   logic [CW-1:0]         cnt_in [NODES];
   logic                  ch_ff, ch_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  valid_ff, valid_in;

   // latched item
   logic [2:0]  op_ff;
   logic [1:0]  peer_ff;
   logic [7:0]  label_ff;
   logic [15:0] inclk_ff [NODES];

   // result payload
   logic [2:0]  kind_ff, kind_in;
   logic [1:0]  tgt_ff, tgt_in;
   logic [7:0]  olab_ff, olab_in;
   logic [4:0]  ocnt_ff, ocnt_in;
   logic [15:0] oclk_ff [NODES];
   logic [15:0] oclk_in [NODES];
   logic        last_ff, last_in;

   logic                  peer_ok;
   logic [1:0]            pidx;
   logic [1:0]            other0, other1, tgt;
   logic [1:0]            marked;
   logic [NODES-1:0]      seen_new;
   logic                  done;
   logic [CW-1:0]         cnt_t, cnt_p;
   logic                  record_ok;
   logic                  item_ok;
   logic [XW-1:0]         in_x [NODES];
   logic [CLOCK_BITS-1:0] in_v [NODES];
   logic [CLOCK_BITS-1:0] mrg [NODES];
   logic [CLOCK_BITS-1:0] clk_nxt [NODES];
   logic [CW-1:0]         rd_idx;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [7:0]            rd_data;

   assign peer_ok = (peer_ff <= NODE_MAX);
   assign pidx    = peer_ok ? peer_ff : 2'd0;
   assign other0  = (node_ff == 2'd0) ? 2'd1 : 2'd0;
   assign other1  = (node_ff == 2'd2) ? 2'd1 : 2'd2;
   assign tgt     = ch_ff ? other1 : other0;
   assign marked  = (op_ff == OP_START) ? node_ff : pidx;
   assign cnt_t   = cnt_ff[tgt];
   assign cnt_p   = cnt_ff[pidx];

   assign seen_new = seen_ff | (NODES'(1) << pidx);

   always_comb begin
      done = 1'b1;
      for (int p = 0; p < NODES; p++) begin
         if (node_ff != 2'(p) && !seen_new[p]) begin
            done = 1'b0;
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_INTERNAL:      item_ok = 1'b1;
         OP_SEND, OP_RECV: item_ok = peer_ok;
         OP_MARKER:        item_ok = peer_ok && (peer_ff != node_ff);
         OP_START:         item_ok = !active_ff;
         default:          item_ok = 1'b0;
      endcase
   end

   assign record_ok = (op_ff == OP_RECV) && peer_ok && active_ff && (peer_ff != node_ff)
                      && !seen_ff[pidx] && (cnt_p < CW'(CHANNEL_DEPTH));

   // merge with saturation of the incoming entries, then bump own entry
   always_comb begin
      for (int p = 0; p < NODES; p++) begin
         in_x[p] = XW'(inclk_ff[p]);
         in_v[p] = (in_x[p] > XW'(CLOCK_MAX)) ? CLOCK_MAX : CLOCK_BITS'(in_x[p]);
         mrg[p]  = (op_ff == OP_RECV && in_v[p] > clk_ff[p]) ? in_v[p] : clk_ff[p];
         clk_nxt[p] = (node_ff == 2'(p) && mrg[p] != CLOCK_MAX)
                      ? mrg[p] + CLOCK_BITS'(1) : mrg[p];
      end
   end

   assign rd_idx  = cmd.rd_next ? idx_ff + CW'(1) : '0;
   assign wr_addr = AW'(pidx) * AW'(CHANNEL_DEPTH) + AW'(cnt_p);
   assign rd_addr = AW'(tgt) * AW'(CHANNEL_DEPTH) + AW'(rd_idx);

   svcn_ram #(
      .WIDTH (8),
      .DEPTH (SD)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.apply_event && record_ok),
      .wr_addr (wr_addr),
      .wr_data (label_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      node_in   = node_ff;
      clk_in    = clk_ff;
      rec_in    = rec_ff;
      active_in = active_ff;
      seen_in   = seen_ff;
      cnt_in    = cnt_ff;
      ch_in     = ch_ff;
      idx_in    = idx_ff;
      valid_in  = cmd.emit ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);
      if (csr_wr_en) begin
         node_in = (csr_wr_data > NODE_MAX) ? NODE_MAX : csr_wr_data;
      end
      if (cmd.load) begin
         ch_in = 1'b0;
      end
      if (cmd.ch_next) begin
         ch_in = 1'b1;
      end
      if (cmd.apply_event) begin
         clk_in = clk_nxt;
         if (record_ok) begin
            cnt_in[pidx] = cnt_p + CW'(1);
         end
      end
      if (cmd.begin_snap) begin
         active_in = 1'b1;
         rec_in    = clk_ff;
         seen_in   = NODES'(1) << marked;
         for (int p = 0; p < NODES; p++) begin
            cnt_in[p] = '0;
         end
      end
      if (cmd.set_mark) begin
         seen_in = seen_new;
      end
      if (cmd.finish) begin
         active_in = 1'b0;
         seen_in   = '0;
         for (int p = 0; p < NODES; p++) begin
            cnt_in[p] = '0;
         end
      end
      if (cmd.rd_en) begin
         idx_in = rd_idx;
      end
   end

   always_comb begin
      kind_in = cmd.kind;
      tgt_in  = 2'd0;
      olab_in = 8'd0;
      ocnt_in = 5'd0;
      last_in = cmd.last;
      for (int p = 0; p < NODES; p++) begin
         oclk_in[p] = 16'd0;
      end
      unique case (cmd.kind)
         KIND_CLOCK: begin
            for (int p = 0; p < NODES; p++) begin
               oclk_in[p] = 16'(clk_nxt[p]);
            end
         end
         KIND_MSG: begin
            tgt_in  = peer_ff;
            olab_in = label_ff;
            for (int p = 0; p < NODES; p++) begin
               oclk_in[p] = 16'(clk_nxt[p]);
            end
         end
         KIND_MARKER: begin
            tgt_in  = tgt;
            olab_in = MARK_LABEL;
         end
         KIND_LOCAL: begin
            for (int p = 0; p < NODES; p++) begin
               oclk_in[p] = 16'(rec_ff[p]);
            end
         end
         KIND_HEADER: begin
            tgt_in  = tgt;
            ocnt_in = 5'(cnt_t);
         end
         KIND_LABEL: begin
            tgt_in  = tgt;
            olab_in = rd_data;
         end
         default: begin
            kind_in = cmd.kind;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff   <= 2'd0;
         active_ff <= 1'b0;
         seen_ff   <= '0;
         ch_ff     <= 1'b0;
         idx_ff    <= '0;
         valid_ff  <= 1'b0;
         for (int p = 0; p < NODES; p++) begin
            clk_ff[p] <= '0;
            rec_ff[p] <= '0;
            cnt_ff[p] <= '0;
         end
      end else begin
         node_ff   <= node_in;
         clk_ff    <= clk_in;
         rec_ff    <= rec_in;
         active_ff <= active_in;
         seen_ff   <= seen_in;
         cnt_ff    <= cnt_in;
         ch_ff     <= ch_in;
         idx_ff    <= idx_in;
         valid_ff  <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         peer_ff  <= req_peer;
         label_ff <= req_label;
         inclk_ff <= req_clock;
      end
      if (cmd.emit) begin
         kind_ff <= kind_in;
         tgt_ff  <= tgt_in;
         olab_ff <= olab_in;
         ocnt_ff <= ocnt_in;
         oclk_ff <= oclk_in;
         last_ff <= last_in;
      end
   end

   assign sts.opcode    = op_ff;
   assign sts.item_ok   = item_ok;
   assign sts.active    = active_ff;
   assign sts.done      = done;
   assign sts.second    = ch_ff;
   assign sts.cnt_zero  = (cnt_t == '0);
   assign sts.lbl_end   = ((idx_ff + CW'(1)) == cnt_t);
   assign sts.slot_free = !valid_ff || rsp_ready;

   assign rsp_valid  = valid_ff;
   assign rsp_kind   = kind_ff;
   assign rsp_target = tgt_ff;
   assign rsp_label  = olab_ff;
   assign rsp_count  = ocnt_ff;
   assign rsp_clock  = oclk_ff;
   assign rsp_last   = last_ff;

endmodule

FILE: rtl/core/snapshot_vector_clock_node.sv
// An item is latched on its transfer in; its first result enters the result
// register once that is free. Internal, send and receive give one result,
// a snapshot opening two markers, a completing marker the local state and
// per channel a header and its labels, one result per cycle out of the label RAM when not stalled.
// Reset (synchronous) clears clock, snapshot state and node id; the label
// store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// snapshot_vector_clock_node
// One node of a three-node system with vector clock and snapshot recording.
// ----------------------------------------------------------------------------
module snapshot_vector_clock_node import svcn_pkg::*; #(
   parameter int CHANNEL_DEPTH = 16,
   parameter int CLOCK_BITS    = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,   // node_id
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,     // peer, label, in_clock_0, in_clock_1, in_clock_2
   input  logic [2:0]  req_tuser,     // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,     // target, out_label, label_count,
                                      // out_clock_0, out_clock_1, out_clock_2
   output logic [2:0]  rsp_tuser,     // kind
   output logic        rsp_tlast
);

   svcn_cmd_type cmd;
   svcn_sts_type sts;

   logic [15:0] in_clock [NODES];
   logic [15:0] out_clock [NODES];
   logic [1:0]  out_target;
   logic [7:0]  out_label;
   logic [4:0]  out_count;

   assign in_clock[0] = req_tdata[25:10];
   assign in_clock[1] = req_tdata[41:26];
   assign in_clock[2] = req_tdata[57:42];

   svcn_ctl u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   svcn_dp #(
      .CHANNEL_DEPTH (CHANNEL_DEPTH),
      .CLOCK_BITS    (CLOCK_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_opcode  (req_tuser),
      .req_peer    (req_tdata[1:0]),
      .req_label   (req_tdata[9:2]),
      .req_clock   (in_clock),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_kind    (rsp_tuser),
      .rsp_target  (out_target),
      .rsp_label   (out_label),
      .rsp_count   (out_count),
      .rsp_clock   (out_clock),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_clock[2], out_clock[1], out_clock[0],
                       out_count, out_label, out_target};

endmodule

FILE: rtl/core/svcn_checker.sv
// ----------------------------------------------------------------------------
// svcn_checker
// Port-level checks of the snapshot vector clock node, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svcn_checker import svcn_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        csr_wr_en,
   input logic [1:0]  csr_wr_data,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic [2:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // stalled result holds
   `SVCN_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled result changed")

   // one item at a time: input closes right after a transfer
   `SVCN_ASSERT(a_one_item, clock, reset, req_tvalid && req_tready |=> !req_tready, "input ready after transfer")

   `SVCN_ASSERT(a_marker_fmt, clock, reset, rsp_tvalid && rsp_tuser == KIND_MARKER |-> rsp_tdata[9:2] == MARK_LABEL && rsp_tdata[62:15] == '0, "bad marker result")

   // single-result items always close, the local state never does
   `SVCN_ASSERT(a_last_kind, clock, reset, rsp_tvalid |-> ((rsp_tuser == KIND_CLOCK || rsp_tuser == KIND_MSG) == rsp_tlast) || rsp_tuser == KIND_MARKER || rsp_tuser == KIND_HEADER || rsp_tuser == KIND_LABEL, "tlast wrong for kind")

   `SVCN_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid && req_tready, "not idle after reset")

endmodule

bind snapshot_vector_clock_node svcn_checker u_svcn_checker (.*);

FILE: test/snapshot_vector_clock_node_test.sv
// ----------------------------------------------------------------------------
// snapshot_vector_clock_node_test
// Self-checking bench for the snapshot vector clock node. A short table of
// directed events opens the run, then random event streams rich in complete
// snapshots follow under several node ids. Every result transfer is checked
// field by field against a typed-in record or an in-bench model of the node's
// clock and snapshot state, with random idling on both stream sides.
// ----------------------------------------------------------------------------
module snapshot_vector_clock_node_test;
   import svcn_pkg::*;

   localparam int CH_DEPTH = 16;
   localparam int QUIET    = 12;       // cycles allowed for a silent item to retire
   localparam int LIMIT    = 400000;
   localparam int USE_MODEL = -1;      // expected results come from the model
   localparam int NONE_DUE  = 0;       // item must produce nothing
   localparam int ONE_DUE   = 1;       // single typed-in result

   localparam logic [2:0] OP_RSVD_LO  = 3'd5;
   localparam logic [2:0] OP_RSVD_MID = 3'd6;
   localparam logic [2:0] OP_RSVD_HI  = 3'd7;
   localparam logic [1:0] PEER_NONE   = 2'd3;

   typedef struct packed {
      logic [2:0]  kind;
      logic [1:0]  target;
      logic [7:0]  lbl;
      logic [4:0]  cnt;
      logic [15:0] c0;
      logic [15:0] c1;
      logic [15:0] c2;
      logic        last;
   } trace_rec_t;

   typedef struct {
      logic [2:0]  op;
      logic [1:0]  peer;
      logic [7:0]  lbl;
      logic [15:0] c0;
      logic [15:0] c1;
      logic [15:0] c2;
      int          n_typed;
      trace_rec_t  rec;
   } stim_row_t;

   localparam trace_rec_t NO_REC = '0;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata   = '0;
   logic [2:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   snapshot_vector_clock_node dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   // model state of the node
   logic [1:0]  self_id;
   logic [15:0] vclk     [3];
   logic        snap_on;
   logic [15:0] snap_clk [3];
   logic        mark_in  [3];
   logic [4:0]  ch_len   [3];
   logic [7:0]  ch_lbl   [3][CH_DEPTH];

   trace_rec_t  step_q[$];       // results of the item just accepted
   trace_rec_t  trace_due_q[$];  // results still owed by the block
   stim_row_t   opening_q[$];
   stim_row_t   closing_q[$];
   bit          event_taken;
   int          marker_pct = 12;
   int          mismatches = 0;
   int          rsp_hold   = 0;
   bit          tx_calm    = 1'b0;
   bit          rx_calm    = 1'b0;
   int          cycle_ct   = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic trace_rec_t rec_of(input logic [2:0] kind, input logic [1:0] target,
                                         input logic [7:0] lbl, input logic [4:0] cnt,
                                         input logic [15:0] c0, c1, c2);
      trace_rec_t r;
      r = '{kind, target, lbl, cnt, c0, c1, c2, 1'b0};
      return r;
   endfunction

   function automatic stim_row_t mk_row(input logic [2:0] op, input logic [1:0] peer,
                                        input logic [7:0] lbl, input logic [15:0] c0, c1, c2,
                                        input int n_typed, input trace_rec_t rec);
      stim_row_t s;
      s.op = op;
      s.peer = peer;
      s.lbl = lbl;
      s.c0 = c0;
      s.c1 = c1;
      s.c2 = c2;
      s.n_typed = n_typed;
      s.rec = rec;
      s.rec.last = 1'b1;
      return s;
   endfunction

   function automatic void add_result(input logic [2:0] kind, input logic [1:0] target,
                                      input logic [7:0] lbl, input logic [4:0] cnt,
                                      input logic [15:0] c0, c1, c2);
      step_q.push_back(rec_of(kind, target, lbl, cnt, c0, c1, c2));
   endfunction

   function automatic void bump_own();
      if (vclk[self_id] != 16'hFFFF)
         vclk[self_id] = vclk[self_id] + 16'd1;
   endfunction

   function automatic void open_snapshot(input logic [1:0] marked);
      snap_on = 1'b1;
      for (int p = 0; p < NODES; p++) begin
         snap_clk[p] = vclk[p];
         mark_in[p] = (p == marked);
         ch_len[p] = '0;
      end
      for (int p = 0; p < NODES; p++)
         if (p != self_id)
            add_result(KIND_MARKER, 2'(p), MARK_LABEL, 5'd0, 16'd0, 16'd0, 16'd0);
   endfunction

   function automatic void close_if_done();
      for (int p = 0; p < NODES; p++)
         if (p != self_id && !mark_in[p])
            return;
      add_result(KIND_LOCAL, 2'd0, 8'd0, 5'd0, snap_clk[0], snap_clk[1], snap_clk[2]);
      for (int p = 0; p < NODES; p++) begin
         if (p == self_id)
            continue;
         add_result(KIND_HEADER, 2'(p), 8'd0, ch_len[p], 16'd0, 16'd0, 16'd0);
         for (int i = 0; i < ch_len[p]; i++)
            add_result(KIND_LABEL, 2'(p), ch_lbl[p][i], 5'd0, 16'd0, 16'd0, 16'd0);
      end
      snap_on = 1'b0;
      for (int p = 0; p < NODES; p++) begin
         mark_in[p] = 1'b0;
         ch_len[p] = '0;
      end
   endfunction

   // Advances the node model by one accepted event; results land in step_q.
   function automatic void node_advance(input logic [2:0] op, input logic [1:0] pr,
                                        input logic [7:0] lbl, input logic [15:0] c0, c1, c2);
      logic [15:0] inc [3];
      trace_rec_t  tail;
      step_q.delete();
      event_taken = 1'b0;
      inc[0] = c0;
      inc[1] = c1;
      inc[2] = c2;
      if ((op == OP_SEND || op == OP_RECV || op == OP_MARKER) && pr > NODE_MAX)
         return;
      case (op)
         OP_INTERNAL: begin
            bump_own();
            add_result(KIND_CLOCK, 2'd0, 8'd0, 5'd0, vclk[0], vclk[1], vclk[2]);
         end
         OP_SEND: begin
            bump_own();
            add_result(KIND_MSG, pr, lbl, 5'd0, vclk[0], vclk[1], vclk[2]);
         end
         OP_RECV: begin
            // in-transit message: channel still open in the running snapshot
            if (snap_on && pr != self_id && !mark_in[pr] && ch_len[pr] < CH_DEPTH) begin
               ch_lbl[pr][ch_len[pr]] = lbl;
               ch_len[pr] = ch_len[pr] + 5'd1;
            end
            for (int p = 0; p < NODES; p++)
               if (inc[p] > vclk[p])
                  vclk[p] = inc[p];
            bump_own();
            add_result(KIND_CLOCK, 2'd0, 8'd0, 5'd0, vclk[0], vclk[1], vclk[2]);
         end
         OP_MARKER: begin
            if (pr == self_id)
               return;
            if (!snap_on)
               open_snapshot(pr);
            else
               mark_in[pr] = 1'b1;
            close_if_done();
         end
         OP_START: begin
            if (snap_on)
               return;
            open_snapshot(self_id);
         end
         default: return;
      endcase
      event_taken = 1'b1;
      if (step_q.size() > 0) begin
         tail = step_q.pop_back();
         tail.last = 1'b1;
         step_q.push_back(tail);
      end
   endfunction

   function automatic logic [15:0] near_clock(input int p, input bit wide);
      int v;
      if (wide && $urandom_range(0, 7) == 0)
         return 16'($urandom);
      if ($urandom_range(0, 9) == 0)
         return 16'd0;
      v = int'(vclk[p]) + int'($urandom_range(0, 6)) - 3;
      if (v < 0)
         v = 0;
      if (v > 65535)
         v = 65535;
      return 16'(v);
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   task automatic send_item(input stim_row_t row);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 14);
      if ($urandom_range(0, 15) == 0)
         tx_calm = !tx_calm;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {6'd0, row.c2, row.c1, row.c0, row.lbl, row.peer};
      req_tuser  <= row.op;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      node_advance(row.op, row.peer, row.lbl, row.c0, row.c1, row.c2);
      if (row.n_typed == USE_MODEL)
         foreach (step_q[i]) trace_due_q.push_back(step_q[i]);
      else if (row.n_typed == ONE_DUE)
         trace_due_q.push_back(row.rec);
   endtask

   // Drop valid, wait for every owed result, then give silent items time to retire.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (trace_due_q.size() != 0) @(posedge clock);
      repeat (QUIET) @(posedge clock);
   endtask

   task automatic set_node(input logic [1:0] id);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= id;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      self_id = (id > NODE_MAX) ? NODE_MAX : id;
   endtask

   task automatic run_phase(input int n_live, input bit wide);
      stim_row_t  row;
      int         live;
      int         r;
      logic [1:0] other;
      live = 0;
      while (live < n_live) begin
         r = $urandom_range(0, 99);
         other = 2'((int'(self_id) + $urandom_range(1, 2)) % 3);
         row = mk_row(OP_INTERNAL, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      16'($urandom), 16'($urandom), 16'($urandom), USE_MODEL, NO_REC);
         if (r < 8) begin
            case ($urandom_range(0, 3))
               0: row.op = OP_RSVD_LO + 3'($urandom_range(0, 2));
               1: begin
                  row.op = OP_SEND + 3'($urandom_range(0, 2));
                  row.peer = PEER_NONE;
               end
               2: begin
                  row.op = OP_MARKER;
                  row.peer = self_id;
               end
               default: row.op = OP_START;
            endcase
         end else if (!snap_on && r < 25) begin
            row.op = (r < 17) ? OP_START : OP_MARKER;
            row.peer = other;
            // now and then keep markers scarce so the channel stores overflow
            marker_pct = ($urandom_range(0, 2) == 0) ? 1 : 12;
         end else if (snap_on && r < 8 + marker_pct) begin
            row.op = OP_MARKER;
            row.peer = other;
         end else if (r < 70) begin
            row.op = OP_RECV;
            row.peer = ($urandom_range(0, 5) == 0) ? self_id : other;
            row.c0 = near_clock(0, wide);
            row.c1 = near_clock(1, wide);
            row.c2 = near_clock(2, wide);
         end else if (r < 85) begin
            row.op = OP_SEND;
            row.peer = 2'($urandom_range(0, 2));
         end
         send_item(row);
         if (event_taken)
            live++;
      end
   endtask

   initial begin
      while (cycle_ct < LIMIT) begin
         @(posedge clock);
         cycle_ct++;
      end
      $display("snapshot_vector_clock_node regression: fail");
      $finish;
   end

   // result side: random stalls, one long hold-off on request
   initial begin
      int         pause;
      trace_rec_t got;
      trace_rec_t want;
      pause = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (rsp_hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (rsp_hold) @(posedge clock);
            rsp_hold = 0;
         end else if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         pause = 0;
         if (rsp_tvalid === 1'b1) begin
            got = '{rsp_tuser, rsp_tdata[1:0], rsp_tdata[9:2], rsp_tdata[14:10],
                    rsp_tdata[30:15], rsp_tdata[46:31], rsp_tdata[62:47], rsp_tlast};
            if (trace_due_q.size() == 0) begin
               $error("result transfer with nothing owed, kind %0d", got.kind);
               mismatches++;
            end else begin
               want = trace_due_q.pop_front();
               check_field("kind", want.kind, got.kind);
               check_field("target", want.target, got.target);
               check_field("out_label", want.lbl, got.lbl);
               check_field("label_count", want.cnt, got.cnt);
               check_field("out_clock_0", want.c0, got.c0);
               check_field("out_clock_1", want.c1, got.c1);
               check_field("out_clock_2", want.c2, got.c2);
               check_field("last", want.last, got.last);
            end
            pause = rx_calm ? 0 : $urandom_range(0, 14);
            if ($urandom_range(0, 15) == 0)
               rx_calm = !rx_calm;
         end
      end
   end

   initial begin
      self_id = 2'd0;
      snap_on = 1'b0;
      for (int p = 0; p < NODES; p++) begin
         vclk[p] = '0;
         snap_clk[p] = '0;
         mark_in[p] = 1'b0;
         ch_len[p] = '0;
      end

      // node 0 from reset
      opening_q.push_back(mk_row(OP_INTERNAL, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, ONE_DUE,
         rec_of(KIND_CLOCK, 2'd0, 8'h00, 5'd0, 16'd1, 16'd0, 16'd0)));
      opening_q.push_back(mk_row(OP_SEND, 2'd2, 8'hFF, 16'h0, 16'h0, 16'h0, ONE_DUE,
         rec_of(KIND_MSG, 2'd2, 8'hFF, 5'd0, 16'd2, 16'd0, 16'd0)));
      opening_q.push_back(mk_row(OP_SEND, PEER_NONE, 8'h12, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RSVD_LO, 2'd1, 8'h00, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RSVD_MID, 2'd2, 8'h5A, 16'h1234, 16'h8000, 16'h00FF,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RSVD_HI, PEER_NONE, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd1, 8'h00, 16'd0, 16'd5, 16'd0, ONE_DUE,
         rec_of(KIND_CLOCK, 2'd0, 8'h00, 5'd0, 16'd3, 16'd5, 16'd0)));
      opening_q.push_back(mk_row(OP_RECV, 2'd0, 8'h33, 16'd9, 16'd0, 16'd2, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_MARKER, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_MARKER, PEER_NONE, 8'h00, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, PEER_NONE, 8'h44, 16'd50, 16'd50, 16'd50,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_START, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_START, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd1, 8'hAA, 16'd0, 16'd7, 16'd0, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd2, 8'h55, 16'd0, 16'd0, 16'd4, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd0, 8'h99, 16'd0, 16'd0, 16'd0, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_MARKER, 2'd1, 8'h00, 16'h0, 16'h0, 16'h0,
         NONE_DUE, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd1, 8'h11, 16'd1, 16'd8, 16'd1, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_RECV, 2'd2, 8'h22, 16'd2, 16'd2, 16'd9, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_MARKER, 2'd2, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      // snapshot opened by an incoming marker, closed by the other one
      opening_q.push_back(mk_row(OP_MARKER, 2'd2, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_INTERNAL, 2'd3, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      opening_q.push_back(mk_row(OP_MARKER, 2'd1, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));

      // saturated clock at the very end, since it never comes back down
      closing_q.push_back(mk_row(OP_RECV, 2'd0, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, ONE_DUE,
         rec_of(KIND_CLOCK, 2'd0, 8'h00, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF)));
      closing_q.push_back(mk_row(OP_INTERNAL, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, ONE_DUE,
         rec_of(KIND_CLOCK, 2'd0, 8'h00, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF)));
      closing_q.push_back(mk_row(OP_SEND, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, ONE_DUE,
         rec_of(KIND_MSG, 2'd0, 8'h00, 5'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF)));
      closing_q.push_back(mk_row(OP_START, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      closing_q.push_back(mk_row(OP_MARKER, 2'd0, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));
      closing_q.push_back(mk_row(OP_MARKER, 2'd2, 8'h00, 16'h0, 16'h0, 16'h0, USE_MODEL, NO_REC));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      set_node(2'd0);
      foreach (opening_q[i]) send_item(opening_q[i]);

      set_node(2'd1);
      run_phase(70, 1'b0);
      set_node(2'd3);                  // out of range, held as node 2
      run_phase(35, 1'b0);
      settle();                        // sender pauses until all results are in
      run_phase(35, 1'b0);
      set_node(2'd0);
      run_phase(20, 1'b0);
      rsp_hold = 400;                  // long receiver hold-off, sender keeps going
      tx_calm = 1'b1;
      run_phase(50, 1'b0);
      set_node(2'd2);
      run_phase(60, 1'b0);
      set_node(2'd1);
      run_phase(60, 1'b1);
      foreach (closing_q[i]) send_item(closing_q[i]);
      settle();

      if (mismatches == 0)
         $display("snapshot_vector_clock_node regression: pass");
      else
         $display("snapshot_vector_clock_node regression: fail");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/svcn_pkg.sv
rtl/core/svcn_ram.sv
rtl/core/svcn_ctl.sv
rtl/core/svcn_dp.sv
rtl/core/snapshot_vector_clock_node.sv
rtl/core/svcn_checker.sv
test/snapshot_vector_clock_node_test.sv
